// ===== design/fbr_pkg.sv =====
// ============================================================================
// fbr_pkg
// Shared types and constants of the framed byte receiver.
// ============================================================================
`default_nettype none

package fbr_pkg;

    // Frame store depth and the index width that follows from it
    localparam int FRAME_LEN = 48;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

    // Configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 8;

    typedef enum logic [2:0] {
        REG_START  = 3'd0,
        REG_SECOND = 3'd1,
        REG_THIRD  = 3'd2,
        REG_KDATA  = 3'd3,
        REG_KRESET = 3'd4,
        REG_KSIGN  = 3'd5,
        REG_END    = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SECOND = 3'd1,
        PH_THIRD  = 3'd2,
        PH_KIND   = 3'd3,
        PH_DATA   = 3'd4,
        PH_END    = 3'd5,
        PH_ERROR  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_SIGN  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [REG_W-1:0] start_byte;
        logic [REG_W-1:0] second_byte;
        logic [REG_W-1:0] third_byte;
        logic [REG_W-1:0] data_kind_byte;
        logic [REG_W-1:0] reset_kind_byte;
        logic [REG_W-1:0] sign_kind_byte;
        logic [REG_W-1:0] end_marker;
    } cfg_t;

    // Result of one byte, less the stored byte itself (that comes from the RAM)
    typedef struct packed {
        logic       stored;
        logic [5:0] store_index;
        logic       frame_done;
        logic [1:0] frame_kind;
        logic       error_seen;
        logic [2:0] phase_now;
    } res_t;

endpackage

`default_nettype wire

// ===== design/framed_byte_receiver.sv =====
// ============================================================================
// framed_byte_receiver
// Byte-serial frame recognizer with a frame store and per-byte status.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one link byte per
//   transfer. Output channel (out_valid/out_ready) returns one result per
//   byte: whether and where the byte went into the frame store, the byte,
//   the frame-done pulse, the frame kind, the error flag and the new phase.
//   Header and marker bytes are set over the APB port (byte address 4*i);
//   the user must do it while the block is idle; the block does not enforce it.
//   Latency: a result is offered the cycle after its input transfer.
//   Throughput: one byte per cycle unless stalled; the phase, fill index and
//   kind update on each accepted byte; each byte costs one frame store access.
//   The output register accepts a new byte in the same cycle that its held
//   result is taken, so no bubble appears while the receiver keeps up.
//   When the receiver stalls, the result holds in the output register (and
//   in the RAM read register) and in_ready drops until it is taken.
//   Reset: phase idle, fill index and kind zero, marker registers zero; the frame
//   store is not cleared, it is only written, so no clearing pass is run.
// ============================================================================
`default_nettype none

module framed_byte_receiver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // APB-style configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fbr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [fbr_pkg::PDATA_W-1:0] pwdata,
    output logic      [fbr_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    // Input byte channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  rx_byte,
    // Result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             stored,
    output logic      [5:0]                  store_index,
    output logic      [7:0]                  stored_byte,
    output logic                             frame_done,
    output logic      [1:0]                  frame_kind,
    output logic                             error_seen,
    output logic      [2:0]                  phase_now
);
    import fbr_pkg::*;

    cfg_t             cfg;
    res_t             res;
    res_t             res_reg;
    logic             out_valid_reg, out_valid_next;
    logic             acc;
    logic             st_we;
    logic [IDX_W-1:0] st_addr;
    logic [7:0]       st_rdata;

    fbr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a byte whenever the output slot is empty or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign acc      = in_valid && in_ready;

    fbr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .res     (res),
        .st_we   (st_we),
        .st_addr (st_addr)
    );

    // Frame store; the write-first read register doubles as the output byte
    fbr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .en    (acc),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (rx_byte),
        .rdata (st_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign stored      = res_reg.stored;
    assign store_index = res_reg.store_index;
    assign stored_byte = res_reg.stored ? st_rdata : 8'd0;
    assign frame_done  = res_reg.frame_done;
    assign frame_kind  = res_reg.frame_kind;
    assign error_seen  = res_reg.error_seen;
    assign phase_now   = res_reg.phase_now;

endmodule

`default_nettype wire

// ===== design/fbr_ram.sv =====
// ============================================================================
// fbr_ram
// Generic single-port synchronous RAM, write-first, registered read data.
// ============================================================================
`default_nettype none

module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds while the port is idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
                rdata     <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/fbr_cfg.sv =====
// ============================================================================
// fbr_cfg
// APB-style register file holding the frame header and marker bytes.
// ============================================================================
`default_nettype none

module fbr_cfg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [fbr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [fbr_pkg::PDATA_W-1:0] pwdata,
    output logic      [fbr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output fbr_pkg::cfg_t               cfg
);
    import fbr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;
    logic [REG_W-1:0] rd_val;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_START:  cfg_next.start_byte      = pwdata[REG_W-1:0];
                REG_SECOND: cfg_next.second_byte     = pwdata[REG_W-1:0];
                REG_THIRD:  cfg_next.third_byte      = pwdata[REG_W-1:0];
                REG_KDATA:  cfg_next.data_kind_byte  = pwdata[REG_W-1:0];
                REG_KRESET: cfg_next.reset_kind_byte = pwdata[REG_W-1:0];
                REG_KSIGN:  cfg_next.sign_kind_byte  = pwdata[REG_W-1:0];
                REG_END:    cfg_next.end_marker      = pwdata[REG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START:  rd_val = cfg_reg.start_byte;
            REG_SECOND: rd_val = cfg_reg.second_byte;
            REG_THIRD:  rd_val = cfg_reg.third_byte;
            REG_KDATA:  rd_val = cfg_reg.data_kind_byte;
            REG_KRESET: rd_val = cfg_reg.reset_kind_byte;
            REG_KSIGN:  rd_val = cfg_reg.sign_kind_byte;
            REG_END:    rd_val = cfg_reg.end_marker;
            default:    rd_val = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-REG_W){1'b0}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/fbr_ctrl.sv =====
// ============================================================================
// fbr_ctrl
// Frame phase sequencer: header checks, kind select, fill index, store writes.
// ============================================================================
`default_nettype none

module fbr_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    acc,
    input  wire logic [7:0]              rx_byte,
    input  fbr_pkg::cfg_t                cfg,
    output fbr_pkg::res_t                res,
    output logic                         st_we,
    output logic [fbr_pkg::IDX_W-1:0]    st_addr
);
    import fbr_pkg::*;

    phase_t           phase_reg,  phase_next;
    logic [IDX_W-1:0] fill_reg,   fill_next;
    kind_t            kind_reg,   kind_next;

    logic             put;
    logic             done;
    logic             err;
    logic [IDX_W-1:0] fill_adv;

    // Saturating advance of the fill index
    assign fill_adv = (fill_reg < IDX_LAST) ? fill_reg + 1'b1 : fill_reg;

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        kind_next  = kind_reg;
        put        = 1'b0;
        done       = 1'b0;
        err        = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == cfg.start_byte)
                begin
                    put        = 1'b1;
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (rx_byte == cfg.second_byte)
                begin
                    put        = 1'b1;
                    phase_next = PH_THIRD;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    fill_next  = '0;
                end
            end
            PH_THIRD:
            begin
                if (rx_byte == cfg.third_byte)
                begin
                    put        = 1'b1;
                    phase_next = PH_KIND;
                end
                else
                begin
                    phase_next = PH_ERROR;
                    err        = 1'b1;
                end
            end
            PH_KIND:
            begin
                if (rx_byte == cfg.data_kind_byte)
                begin
                    put        = 1'b1;
                    kind_next  = KIND_DATA;
                    phase_next = PH_DATA;
                end
                else if (rx_byte == cfg.reset_kind_byte)
                begin
                    put        = 1'b1;
                    kind_next  = KIND_RESET;
                    phase_next = PH_END;
                end
                else if (rx_byte == cfg.sign_kind_byte)
                begin
                    put        = 1'b1;
                    kind_next  = KIND_SIGN;
                    phase_next = PH_END;
                end
                else
                begin
                    phase_next = PH_ERROR;
                    err        = 1'b1;
                end
            end
            PH_DATA:
            begin
                put = 1'b1;
                if (fill_adv >= IDX_LAST)
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                if (rx_byte == cfg.end_marker)
                begin
                    put        = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                // Error phase: drop the byte and clear everything
                phase_next = PH_IDLE;
                fill_next  = '0;
                kind_next  = KIND_DATA;
            end
        endcase
        if (put)
        begin
            fill_next = done ? '0 : fill_adv;
        end
    end

    assign st_we   = put;
    assign st_addr = fill_reg;

    assign res.stored      = put;
    assign res.store_index = put ? 6'(fill_reg) : 6'd0;
    assign res.frame_done  = done;
    assign res.frame_kind  = kind_next;
    assign res.error_seen  = err;
    assign res.phase_now   = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            kind_reg  <= KIND_DATA;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the framed byte receiver: a short scripted run of
// header, kind, error and end-marker cases, then random byte streams shaped
// as mostly well-formed frames under several marker settings, with random
// sender bursts, receiver stalls and a per-byte status tracker as checker.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

    import fbr_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int     ITEMS_PER_PLAN = 290;
    localparam int     REPORT_LIMIT   = 10;
    localparam longint RUN_LIMIT_NS   = 64'd10_000_000;

    // Expected status of one byte, in the order the result ports list it
    typedef struct packed {
        logic       stored;
        logic [5:0] index;
        logic [7:0] data;
        logic       done;
        logic [1:0] kind;
        logic       err;
        logic [2:0] ph;
    } byte_status_t;

    // One scripted byte; pinned rows carry a hand-typed expected status
    typedef struct packed {
        logic [7:0]   rx;
        logic         pinned;
        byte_status_t want;
    } script_row_t;

    // Marker settings walked by the random part
    typedef enum logic [2:0] {
        PLAN_ZEROS,
        PLAN_ONES,
        PLAN_RANDOM,
        PLAN_RS_SAME,
        PLAN_DR_SAME,
        PLAN_END_IS_START,
        PLAN_COUNT
    } plan_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HALF,
        SINK_RUNS
    } sink_mode_t;

    localparam cfg_t SCRIPT_CFG = '{8'hA5, 8'h5A, 8'hC3, 8'h01, 8'h02, 8'h03, 8'h7E};

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [7:0]          rx_byte   = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                stored;
    logic [5:0]          store_index;
    logic [7:0]          stored_byte;
    logic                frame_done;
    logic [1:0]          frame_kind;
    logic                error_seen;
    logic [2:0]          phase_now;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    framed_byte_receiver u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stored      (stored),
        .store_index (store_index),
        .stored_byte (stored_byte),
        .frame_done  (frame_done),
        .frame_kind  (frame_kind),
        .error_seen  (error_seen),
        .phase_now   (phase_now)
    );

    // ------------------------------------------------------------------------
    // Frame tracker: mirrors the receiver's phase, fill index, kind and
    // markers. The frame store itself is never read back, so it is not kept.
    // ------------------------------------------------------------------------
    phase_t       trk_phase = PH_IDLE;
    logic [5:0]   trk_fill  = '0;
    kind_t        trk_kind  = KIND_DATA;
    cfg_t         trk_cfg   = '0;

    byte_status_t status_due [$];
    int           mismatch_cnt = 0;
    int           burst_left   = 0;

    // Write one byte at the fill index; hold the index once it reaches the
    // last slot so further writes land on that slot again
    function automatic void stash(input logic [7:0] b, inout byte_status_t s);
        logic [5:0] at;
        at = (trk_fill > IDX_LAST) ? IDX_LAST : trk_fill;
        s.stored = 1'b1;
        s.index  = at;
        s.data   = b;
        trk_fill = (at < IDX_LAST) ? at + 6'd1 : at;
    endfunction

    // Advance the tracker by one accepted byte and return the status it earns
    function automatic byte_status_t track_byte(input logic [7:0] b);
        byte_status_t s;
        s = '0;
        case (trk_phase)
            PH_IDLE:
                if (b == trk_cfg.start_byte)
                begin
                    stash(b, s);
                    trk_phase = PH_SECOND;
                end
            PH_SECOND:
                if (b == trk_cfg.second_byte)
                begin
                    stash(b, s);
                    trk_phase = PH_THIRD;
                end
                else
                begin
                    // quiet drop back to idle, index rewinds as well
                    trk_phase = PH_IDLE;
                    trk_fill  = '0;
                end
            PH_THIRD:
                if (b == trk_cfg.third_byte)
                begin
                    stash(b, s);
                    trk_phase = PH_KIND;
                end
                else
                begin
                    trk_phase = PH_ERROR;
                    s.err     = 1'b1;
                end
            PH_KIND:
                // data kind wins over reset, reset over signature
                if (b == trk_cfg.data_kind_byte)
                begin
                    stash(b, s);
                    trk_kind  = KIND_DATA;
                    trk_phase = PH_DATA;
                end
                else if (b == trk_cfg.reset_kind_byte)
                begin
                    stash(b, s);
                    trk_kind  = KIND_RESET;
                    trk_phase = PH_END;
                end
                else if (b == trk_cfg.sign_kind_byte)
                begin
                    stash(b, s);
                    trk_kind  = KIND_SIGN;
                    trk_phase = PH_END;
                end
                else
                begin
                    trk_phase = PH_ERROR;
                    s.err     = 1'b1;
                end
            PH_DATA:
            begin
                stash(b, s);
                if (trk_fill >= IDX_LAST)
                    trk_phase = PH_END;
            end
            PH_END:
                if (b == trk_cfg.end_marker)
                begin
                    stash(b, s);
                    s.done    = 1'b1;
                    trk_fill  = '0;
                    trk_phase = PH_IDLE;
                end
            default:
            begin
                // error phase: drop the byte and clear everything
                trk_phase = PH_IDLE;
                trk_fill  = '0;
                trk_kind  = KIND_DATA;
            end
        endcase
        s.kind = trk_kind;
        s.ph   = trk_phase;
        return s;
    endfunction

    // Choose the next random byte from where the tracker stands: mostly the
    // byte that moves the frame on, sometimes noise that breaks it
    function automatic logic [7:0] pick_byte();
        logic [7:0] noise;
        int         roll;
        noise = 8'($urandom);
        roll  = $urandom_range(0, 99);
        case (trk_phase)
            PH_IDLE:   return (roll < 80) ? trk_cfg.start_byte : noise;
            PH_SECOND: return (roll < 90) ? trk_cfg.second_byte : noise;
            PH_THIRD:  return (roll < 92) ? trk_cfg.third_byte : noise;
            PH_KIND:
                if (roll < 30)
                    return trk_cfg.data_kind_byte;
                else if (roll < 60)
                    return trk_cfg.reset_kind_byte;
                else if (roll < 90)
                    return trk_cfg.sign_kind_byte;
                else
                    return noise;
            PH_END:    return (roll < 60) ? trk_cfg.end_marker : noise;
            default:   return noise;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Scripted bytes, run under SCRIPT_CFG. Pinned rows are easy to read off
    // by hand; the rest are checked against the tracker.
    // Field order: stored, index, byte, done, kind, err, phase.
    // ------------------------------------------------------------------------
    script_row_t script [27] = '{
        // idle: a non-start byte is ignored
        '{8'h00, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, KIND_DATA,  1'b0, PH_IDLE}},
        '{8'hA5, 1'b1, {1'b1, 6'd0, 8'hA5, 1'b0, KIND_DATA,  1'b0, PH_SECOND}},
        // wrong second byte: quietly back to idle
        '{8'h00, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, KIND_DATA,  1'b0, PH_IDLE}},
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        // wrong third byte: error, then the next byte is dropped
        '{8'hFF, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, KIND_DATA,  1'b1, PH_ERROR}},
        '{8'h12, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, KIND_DATA,  1'b0, PH_IDLE}},
        // reset command frame with a stray byte before the end marker
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hC3, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h7E, 1'b1, {1'b1, 6'd4, 8'h7E, 1'b1, KIND_RESET, 1'b0, PH_IDLE}},
        // signature command frame
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hC3, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h7E, 1'b1, {1'b1, 6'd4, 8'h7E, 1'b1, KIND_SIGN,  1'b0, PH_IDLE}},
        // unknown kind byte: error, kind persists until the clear
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hC3, 1'b0, '0},
        '{8'hFF, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, KIND_SIGN,  1'b1, PH_ERROR}},
        '{8'h00, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, KIND_DATA,  1'b0, PH_IDLE}},
        // open a data body; the random part carries it on
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hC3, 1'b0, '0},
        '{8'h01, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Sender: bursts of back-to-back transfers split by random gaps. Hold
    // valid and the byte until the transfer, then log the expected status.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic pinned,
                             input byte_status_t want, output logic moved);
        byte_status_t s;
        phase_t       was;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transfer taken at this edge
        was = trk_phase;
        s   = track_byte(b);
        status_due.push_back(pinned ? want : s);
        moved = s.stored || s.err || (s.ph != was);
    endtask

    // Drop valid and wait until every expected status has been returned,
    // then let the output register settle
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all seven marker registers over APB, setup then access cycle
    task automatic load_markers(input cfg_t c);
        for (int r = REG_START; r <= REG_END; r++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'(4 * r);
            // upper data bits are noise; only the low byte is a marker
            pwdata  <= {24'($urandom), c[8 * (REG_END - r) +: 8]};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        trk_cfg  = c;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: switch between randomly chosen stall patterns,
    // including an always-ready stretch
    // ------------------------------------------------------------------------
    sink_mode_t sink_mode = SINK_OPEN;
    int         mode_left = 0;
    int         run_left  = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(32, 200);
        end
        else
            mode_left <= mode_left - 1;

        case (sink_mode)
            SINK_OPEN:  out_ready <= 1'b1;
            SINK_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            SINK_HALF:  out_ready <= 1'($urandom_range(0, 1));
            default:
                // long runs of stall and flow
                if (run_left == 0)
                begin
                    out_ready <= ~out_ready;
                    run_left  <= $urandom_range(1, 12);
                end
                else
                    run_left <= run_left - 1;
        endcase
    end

    // ------------------------------------------------------------------------
    // Checker: compare every result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string what, input byte_status_t want,
                                input byte_status_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected stored=%0d idx=%0d byte=%02h done=%0d",
                     $realtime, what,
                     want.stored, want.index, want.data, want.done);
            $display("    expected kind=%0d err=%0d phase=%0d",
                     want.kind, want.err, want.ph);
            $display("    got stored=%0d idx=%0d byte=%02h done=%0d",
                     got.stored, got.index, got.data, got.done);
            $display("    got kind=%0d err=%0d phase=%0d",
                     got.kind, got.err, got.ph);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        byte_status_t got;
        byte_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {stored, store_index, stored_byte, frame_done,
                   frame_kind, error_seen, phase_now};
            if (status_due.size() == 0)
                log_mismatch("result with none due", '0, got);
            else
            begin
                want = status_due.pop_front();
                if (got.stored !== want.stored || got.index !== want.index ||
                    got.data !== want.data || got.done !== want.done ||
                    got.kind !== want.kind || got.err !== want.err ||
                    got.ph !== want.ph)
                    log_mismatch("status mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, scripted bytes, then one random stream per marker plan
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic  moved;
        int    counted;
        cfg_t  plan_cfg;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_markers(SCRIPT_CFG);
        foreach (script[i])
            send_byte(script[i].rx, script[i].pinned, script[i].want, moved);
        drain();

        for (int p = PLAN_ZEROS; p < PLAN_COUNT; p++)
        begin
            plan_cfg = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom)};
            case (plan_t'(p))
                PLAN_ZEROS:        plan_cfg = '0;
                PLAN_ONES:         plan_cfg = '1;
                PLAN_RS_SAME:      plan_cfg.sign_kind_byte  = plan_cfg.reset_kind_byte;
                PLAN_DR_SAME:      plan_cfg.reset_kind_byte = plan_cfg.data_kind_byte;
                PLAN_END_IS_START: plan_cfg.end_marker      = plan_cfg.start_byte;
                default:           ;
            endcase
            load_markers(plan_cfg);

            // count only bytes the receiver acts on, not ignored noise
            counted = 0;
            while (counted < ITEMS_PER_PLAN)
            begin
                send_byte(pick_byte(), 1'b0, '0, moved);
                if (moved)
                    counted++;
            end
            drain();
        end

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case a handshake hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fbr_pkg.sv
design/fbr_ram.sv
design/fbr_cfg.sv
design/fbr_ctrl.sv
design/framed_byte_receiver.sv
tb/tb_top.sv
